// ===== hdl/rbf_pkg.sv =====
// ============================================================================
// rbf_pkg - shared types and constants for the ring byte FIFO
// Holds the payload structs, the status and command codes, the controller
// state type and the command/status bundles between controller and datapath.
// ============================================================================
package rbf_pkg;

  // Queue size. It must be a power of two; the queue holds DEPTH-1 bytes.
  localparam int DEPTH = 4096;
  localparam int IDX_W = $clog2(DEPTH);

  // Widths fixed by the request and result fields.
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 12;

  // Width wide enough to compare a length against the free room.
  localparam int CMP_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

  // Direction codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_NO_DATA = 2'd2,
    ST_OUTSIDE = 2'd3
  } rbf_status_t;

  typedef struct packed {
    logic              cmd;
    logic              first;
    logic [LEN_W-1:0]  txn_length;
    logic [BYTE_W-1:0] byte_in;
  } rbf_in_t;

  typedef struct packed {
    rbf_status_t       status;
    logic [BYTE_W-1:0] byte_out;
    logic [FILL_W-1:0] fill_level;
  } rbf_out_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } rbf_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // register the incoming request
    logic exec;     // apply the request and load the result register
  } rbf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // the result register can take a new result this cycle
  } rbf_sts_t;

endpackage

// ===== hdl/rbf_ctrl.sv =====
// ============================================================================
// rbf_ctrl - request sequencer for the ring byte FIFO
// Two-state controller: take a request, then apply it once the result
// register has room.
// ============================================================================
module rbf_ctrl import rbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rbf_sts_t sts,
  output rbf_cmd_t cmd
);

  rbf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = !rst_n;
        cmd.capture = in_valid && rst_n;
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/rbf_datapath.sv =====
// ============================================================================
// rbf_datapath - storage, pointers and transaction state of the ring FIFO
// Holds the byte store, the read and write indexes, the open transaction
// and the result register.
// ============================================================================
module rbf_datapath import rbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rbf_cmd_t cmd,
  output rbf_sts_t sts,
  input  rbf_in_t  in_data,
  input  logic     out_stall,
  output logic     out_valid,
  output rbf_out_t out_data
);

  // Byte store, read port registered.
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  rbf_in_t item_r;

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             acc_r, acc_nxt;
  logic             is_pop_r, is_pop_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;

  logic             out_valid_r, out_valid_nxt;
  rbf_out_t         out_r, out_nxt;

  logic [IDX_W-1:0]  fill;
  logic [IDX_W-1:0]  fill_after;
  logic [CMP_W-1:0]  push_need;
  logic              active;
  logic              do_move;
  logic              mem_we;

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  assign fill      = wr_idx_r - rd_idx_r;
  assign push_need = CMP_W'(item_r.txn_length) + CMP_W'(fill);

  always_comb begin
    acc_nxt    = acc_r;
    is_pop_nxt = is_pop_r;
    remain_nxt = remain_r;
    active     = 1'b0;
    if (item_r.first) begin
      is_pop_nxt = (item_r.cmd == CMD_POP);
      if (item_r.txn_length == '0) begin
        acc_nxt    = 1'b0;
        remain_nxt = '0;
      end else begin
        if (item_r.cmd == CMD_POP) begin
          acc_nxt = (CMP_W'(item_r.txn_length) <= CMP_W'(fill));
        end else begin
          acc_nxt = (push_need <= CMP_W'(DEPTH - 1));
        end
        remain_nxt = item_r.txn_length - LEN_W'(1);
        active     = 1'b1;
      end
    end else if (remain_r != '0) begin
      remain_nxt = remain_r - LEN_W'(1);
      active     = 1'b1;
    end
  end

  assign do_move    = active && acc_nxt;
  assign mem_we     = cmd.exec && do_move && !is_pop_nxt;
  assign wr_idx_nxt = (do_move && !is_pop_nxt) ? wr_idx_r + IDX_W'(1) : wr_idx_r;
  assign rd_idx_nxt = (do_move &&  is_pop_nxt) ? rd_idx_r + IDX_W'(1) : rd_idx_r;
  assign fill_after = wr_idx_nxt - rd_idx_nxt;

  always_comb begin
    out_nxt.fill_level = FILL_W'(fill_after);
    out_nxt.byte_out   = '0;
    if (!active) begin
      out_nxt.status = ST_OUTSIDE;
    end else if (acc_nxt) begin
      out_nxt.status = ST_OK;
      if (is_pop_nxt) begin
        out_nxt.byte_out = rd_data_r;
      end
    end else if (is_pop_nxt) begin
      out_nxt.status = ST_NO_DATA;
    end else begin
      out_nxt.status = ST_NO_ROOM;
    end
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // The read address only moves in the execute cycle, so the data read
  // during the accept cycle is current when the request is applied.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= item_r.byte_in;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      acc_r       <= 1'b0;
      is_pop_r    <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.exec) begin
        wr_idx_r <= wr_idx_nxt;
        rd_idx_r <= rd_idx_nxt;
        acc_r    <= acc_nxt;
        is_pop_r <= is_pop_nxt;
        remain_r <= remain_nxt;
      end
    end
  end

endmodule

// ===== hdl/ring_byte_fifo_atomic_burst_core.sv =====
// ============================================================================
// ring_byte_fifo_atomic_burst_core - circular byte FIFO with atomic bursts
// A power-of-two ring of bytes that holds at most DEPTH-1 bytes. Traffic
// comes in transactions: the request flagged first carries the direction
// and the byte count, and the whole transaction is accepted or refused up
// front against the fill level at that moment. Every request, the first
// one included, returns one result with a status, the popped byte (zero
// unless a pop succeeds) and the fill level afterwards; only a request
// inside an accepted transaction moves a byte. Requests beyond the
// declared count, and a first request with a count of zero, report that
// they fall outside any transaction. A new first request abandons the
// open transaction without undoing bytes already moved. Each request is
// first accepted and then applied, because the byte store has a registered
// read port and the pop data is read in the accept cycle. A stalled result
// register holds the request in the execute state; the next request can be
// accepted while a finished result still waits to be taken. The byte store
// is not cleared at reset; only entries already written are ever popped.
// ============================================================================
module ring_byte_fifo_atomic_burst_core import rbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rbf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rbf_out_t out_data
);

  // Command and status bundles between sequencer and datapath.
  rbf_cmd_t cmd;
  rbf_sts_t sts;

  // The sequencer decides when a request is taken and when it is applied.
  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the store, the indexes, the transaction state and
  // the result register.
  rbf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/rbf_checker.sv =====
// ============================================================================
// rbf_checker - port-level checks for the ring byte FIFO
// Watches the top-level ports and is bound to the top level.
// ============================================================================
module rbf_checker import rbf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input rbf_out_t out_data
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a successful request can return a nonzero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.byte_out == '0)
    else $error("nonzero byte on a failed or outside request");

  // One request is in flight at a time: an accepted request blocks the next.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ring_byte_fifo_atomic_burst_core rbf_checker u_rbf_checker (.*);
